// ===== rtl/core/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

   // Fixed field widths of the access and result items.
   localparam int ADDR_W      = 32;
   localparam int TAG_W       = 32;
   localparam int STAMP_W     = 32;
   localparam int SET_OUT_W   = 8;
   localparam int LFSR_W      = 16;
   localparam int RECIP_W     = 33;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_BITS = 3'd0,
      CSR_SET_BITS    = 3'd1,
      CSR_WAYS_USED   = 3'd2,
      CSR_REPLACEMENT = 3'd3,
      CSR_WRITE_MODE  = 3'd4
   } csr_index_type;

   // Replacement policy codes; the unused code behaves as random.
   localparam logic [1:0] REPL_FIFO   = 2'd0;
   localparam logic [1:0] REPL_LRU    = 2'd1;
   localparam logic [1:0] REPL_RANDOM = 2'd2;

   localparam logic WRITE_BACK    = 1'b0;
   localparam logic WRITE_THROUGH = 1'b1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register reset values.
   localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
   localparam logic [3:0] SET_BITS_RST    = 4'd6;
   localparam logic [3:0] WAYS_USED_RST   = 4'd4;
   localparam logic [1:0] REPLACEMENT_RST = REPL_LRU;
   localparam logic       WRITE_MODE_RST  = WRITE_BACK;

   localparam logic [3:0]        SET_BITS_CAP = 4'd8;
   localparam logic [LFSR_W-1:0] LFSR_SEED    = 16'hACE1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } ctl_state_type;

   // Decision of the lookup logic for one access.
   typedef struct packed {
      logic hit;
      logic alloc;
      logic fifo_step;
      logic lfsr_step;
   } lookup_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ctc_if.sv =====
`default_nettype none

// Access channel.
interface ctc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [ctc_pkg::ADDR_W-1:0] address;

   modport source (output valid, output operation, output address, input ready);
   modport sink   (input valid, input operation, input address, output ready);
endinterface

// Result channel.
interface ctc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [ctc_pkg::SET_OUT_W-1:0] set_index;
   logic [ctc_pkg::TAG_W-1:0]     tag_value;

   modport source (output valid, output hit, output set_index, output tag_value, input ready);
   modport sink   (input valid, input hit, input set_index, input tag_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ctc_row_ram.sv =====
`default_nettype none

// One row per set holding every way: tags, stamps, valid and dirty marks and
// the FIFO pointer. A row never written since reset reads as all clear
// (tags excepted), tracked by one live flag per row.
module ctc_row_ram #(
   parameter int SETS  = 256,
   parameter int WAYS  = 8,
   parameter int SET_W = 8,
   parameter int WAY_W = 3
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         rd_en,
   input  wire logic [SET_W-1:0]                             rd_addr,
   output logic      [WAYS-1:0][ctc_pkg::TAG_W-1:0]         rd_tags,
   output logic      [WAYS-1:0][ctc_pkg::STAMP_W-1:0]       rd_stamps,
   output logic      [WAYS-1:0]                              rd_valid,
   output logic      [WAYS-1:0]                              rd_dirty,
   output logic      [WAY_W-1:0]                             rd_ptr,
   input  wire logic                                         wr_en,
   input  wire logic [SET_W-1:0]                             wr_addr,
   input  wire logic [WAYS-1:0][ctc_pkg::TAG_W-1:0]         wr_tags,
   input  wire logic [WAYS-1:0][ctc_pkg::STAMP_W-1:0]       wr_stamps,
   input  wire logic [WAYS-1:0]                              wr_valid,
   input  wire logic [WAYS-1:0]                              wr_dirty,
   input  wire logic [WAY_W-1:0]                             wr_ptr
);

   localparam int FLAG_W = 2 * WAYS + WAY_W;

   logic [WAYS*ctc_pkg::TAG_W-1:0]   tag_mem   [SETS];
   logic [WAYS*ctc_pkg::STAMP_W-1:0] stamp_mem [SETS];
   logic [FLAG_W-1:0]                flag_mem  [SETS];
   logic [SETS-1:0]                  row_live_ff;

   logic [WAYS*ctc_pkg::TAG_W-1:0]   tag_q_ff;
   logic [WAYS*ctc_pkg::STAMP_W-1:0] stamp_q_ff;
   logic [FLAG_W-1:0]                flag_q_ff;
   logic                             live_q_ff;

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr]   <= wr_tags;
         stamp_mem[wr_addr] <= wr_stamps;
         flag_mem[wr_addr]  <= {wr_ptr, wr_dirty, wr_valid};
      end
   end

   // Memory read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_q_ff   <= tag_mem[rd_addr];
         stamp_q_ff <= stamp_mem[rd_addr];
         flag_q_ff  <= flag_mem[rd_addr];
      end
   end

   // Live flags are cleared at once by reset, so no clearing pass is needed.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
         live_q_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            row_live_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            live_q_ff <= row_live_ff[rd_addr];
         end
      end
   end

   // A row that was never written reads as its reset value.
   always_comb begin
      rd_tags   = tag_q_ff;
      rd_stamps = live_q_ff ? stamp_q_ff : '0;
      rd_valid  = live_q_ff ? flag_q_ff[WAYS-1:0] : '0;
      rd_dirty  = live_q_ff ? flag_q_ff[2*WAYS-1:WAYS] : '0;
      rd_ptr    = live_q_ff ? flag_q_ff[FLAG_W-1:2*WAYS] : '0;
   end

endmodule

`default_nettype wire

// ===== rtl/core/ctc_lookup.sv =====
`default_nettype none

// Tag match, victim choice and the new contents of the set row.
module ctc_lookup #(
   parameter int WAYS   = 8,
   parameter int WAY_W  = 3,
   parameter int WCNT_W = 4
) (
   input  wire logic [WAYS-1:0][ctc_pkg::TAG_W-1:0]   row_tags,
   input  wire logic [WAYS-1:0][ctc_pkg::STAMP_W-1:0] row_stamps,
   input  wire logic [WAYS-1:0]                        row_valid,
   input  wire logic [WAYS-1:0]                        row_dirty,
   input  wire logic [WAY_W-1:0]                       row_ptr,
   input  wire logic                                   operation,
   input  wire logic [ctc_pkg::TAG_W-1:0]              tag,
   input  wire logic [WCNT_W-1:0]                      ways_eff,
   input  wire logic [1:0]                             replacement,
   input  wire logic                                   write_mode,
   input  wire logic [WAY_W-1:0]                       rnd_way,
   input  wire logic [ctc_pkg::STAMP_W-1:0]            stamp_new,
   output ctc_pkg::lookup_ctl_type                     ctl,
   output logic      [WAYS-1:0][ctc_pkg::TAG_W-1:0]   new_tags,
   output logic      [WAYS-1:0][ctc_pkg::STAMP_W-1:0] new_stamps,
   output logic      [WAYS-1:0]                        new_valid,
   output logic      [WAYS-1:0]                        new_dirty,
   output logic      [WAY_W-1:0]                       new_ptr
);

   logic                         hit;
   logic [WAY_W-1:0]             hit_way;
   logic                         free_found;
   logic [WAY_W-1:0]             free_way;
   logic [WAY_W-1:0]             lru_way;
   logic [ctc_pkg::STAMP_W-1:0]  lru_stamp;
   logic [WAY_W-1:0]             fifo_way;
   logic [WCNT_W-1:0]            fifo_inc;
   logic [WAY_W-1:0]             victim;
   logic                         wb_write;
   logic                         alloc;
   logic                         is_lru;

   assign wb_write = (write_mode == ctc_pkg::WRITE_BACK) && (operation == ctc_pkg::OP_WRITE);
   assign is_lru   = (replacement == ctc_pkg::REPL_LRU);

   // Tag match over the ways in use; the highest matching way wins.
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if ((WCNT_W'(w) < ways_eff) && row_valid[w] && (row_tags[w] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // Lowest invalid way in use.
   always_comb begin
      free_found = 1'b0;
      free_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if ((WCNT_W'(w) < ways_eff) && !row_valid[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
   end

   // Oldest stamp, lowest way on ties.
   always_comb begin
      lru_way   = '0;
      lru_stamp = row_stamps[0];
      for (int w = 1; w < WAYS; w++) begin
         if ((WCNT_W'(w) < ways_eff) && (row_stamps[w] < lru_stamp)) begin
            lru_way   = WAY_W'(w);
            lru_stamp = row_stamps[w];
         end
      end
   end

   // Round-robin pointer; an out-of-range pointer names way 0.
   always_comb begin
      fifo_way = (WCNT_W'(row_ptr) < ways_eff) ? row_ptr : '0;
      fifo_inc = WCNT_W'(fifo_way) + WCNT_W'(1);
   end

   // Access decision and victim.
   always_comb begin
      alloc = !hit && !((write_mode == ctc_pkg::WRITE_THROUGH) &&
                        (operation == ctc_pkg::OP_WRITE));
      ctl.hit       = hit;
      ctl.alloc     = alloc;
      ctl.fifo_step = alloc && !free_found && (replacement == ctc_pkg::REPL_FIFO);
      ctl.lfsr_step = alloc && !free_found && (replacement != ctc_pkg::REPL_FIFO) && !is_lru;
      priority if (hit) begin
         victim = hit_way;
      end else if (free_found) begin
         victim = free_way;
      end else if (replacement == ctc_pkg::REPL_FIFO) begin
         victim = fifo_way;
      end else if (is_lru) begin
         victim = lru_way;
      end else begin
         victim = rnd_way;
      end
   end

   // New row contents.
   always_comb begin
      new_tags   = row_tags;
      new_stamps = row_stamps;
      new_valid  = row_valid;
      new_dirty  = row_dirty;
      new_ptr    = row_ptr;
      if (hit) begin
         if (is_lru) begin
            new_stamps[victim] = stamp_new;
         end
         if (wb_write) begin
            new_dirty[victim] = 1'b1;
         end
      end else if (alloc) begin
         new_valid[victim] = 1'b1;
         new_tags[victim]  = tag;
         new_dirty[victim] = wb_write;
         if (is_lru) begin
            new_stamps[victim] = stamp_new;
         end
         if (ctl.fifo_step) begin
            new_ptr = (fifo_inc == ways_eff) ? '0 : WAY_W'(fifo_inc);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/set_assoc_cache_tag_controller_core.sv =====
// A result is offered from the result register, loaded in the row update after
// the access transfer. No access is taken while a row update runs: the set row
// is read and written back in the tag RAM, which has one read and one write port.
// Reset (synchronous): clears control, the access counter, the LFSR and the
// row live flags and restores the configuration registers.
`default_nettype none

module set_assoc_cache_tag_controller_core #(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ctc_req_if.sink                                 req_bus,
   ctc_rsp_if.source                               rsp_bus,
   input  wire logic                               csr_write_en,
   input  wire logic [ctc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ctc_pkg::CSR_DATA_W-1:0]     csr_data
);

   // The user must keep MAX_SETS a power of two; the core does not enforce it.
   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);
   localparam int PROD_W = ctc_pkg::LFSR_W + ctc_pkg::RECIP_W;

   // Configuration registers.
   logic [4:0] offset_bits_ff;
   logic [3:0] set_bits_ff;
   logic [3:0] ways_used_ff;
   logic [1:0] replacement_ff;
   logic       write_mode_ff;

   ctc_pkg::ctl_state_type state_ff, state_in;

   logic                            op_ff;
   logic [SET_W-1:0]                set_ff;
   logic [ctc_pkg::TAG_W-1:0]       tag_ff;
   logic [ctc_pkg::LFSR_W-1:0]      quot_ff;
   logic [ctc_pkg::STAMP_W-1:0]     counter_ff;
   logic [ctc_pkg::LFSR_W-1:0]      lfsr_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [ctc_pkg::SET_OUT_W-1:0]   rsp_set_ff;
   logic [ctc_pkg::TAG_W-1:0]       rsp_tag_ff;

   logic                            req_ready;
   logic                            accept;
   logic                            update;
   logic [ctc_pkg::ADDR_W-1:0]      line;
   logic [3:0]                      set_bits_eff;
   logic [8:0]                      set_mask;
   logic [7:0]                      set_raw;
   logic [SET_W-1:0]                set_idx;
   logic [ctc_pkg::TAG_W-1:0]       tag_cur;
   logic [WCNT_W-1:0]               ways_eff;
   logic [WAY_W-1:0]                recip_idx;
   logic [ctc_pkg::RECIP_W-1:0]     recip_tab [MAX_WAYS];
   logic [PROD_W-1:0]               recip_prod;
   logic [ctc_pkg::LFSR_W-1:0]      lfsr_nxt;
   logic [ctc_pkg::LFSR_W-1:0]      rnd_rem;
   logic [WAY_W-1:0]                rnd_way;
   logic [ctc_pkg::STAMP_W-1:0]     stamp_new;

   logic [MAX_WAYS-1:0][ctc_pkg::TAG_W-1:0]   rd_tags, new_tags;
   logic [MAX_WAYS-1:0][ctc_pkg::STAMP_W-1:0] rd_stamps, new_stamps;
   logic [MAX_WAYS-1:0]                       rd_valid, new_valid;
   logic [MAX_WAYS-1:0]                       rd_dirty, new_dirty;
   logic [WAY_W-1:0]                          rd_ptr, new_ptr;
   ctc_pkg::lookup_ctl_type                   ctl;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= ctc_pkg::OFFSET_BITS_RST;
         set_bits_ff    <= ctc_pkg::SET_BITS_RST;
         ways_used_ff   <= ctc_pkg::WAYS_USED_RST;
         replacement_ff <= ctc_pkg::REPLACEMENT_RST;
         write_mode_ff  <= ctc_pkg::WRITE_MODE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ctc_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            ctc_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_data[3:0];
            ctc_pkg::CSR_WAYS_USED:   ways_used_ff   <= csr_data[3:0];
            ctc_pkg::CSR_REPLACEMENT: replacement_ff <= csr_data[1:0];
            ctc_pkg::CSR_WRITE_MODE:  write_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective associativity.
   always_comb begin
      priority if (ways_used_ff == 4'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (32'(ways_used_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_used_ff);
      end
   end

   // Address split into set and tag.
   always_comb begin
      line         = req_bus.address >> offset_bits_ff;
      set_bits_eff = (set_bits_ff > ctc_pkg::SET_BITS_CAP) ? ctc_pkg::SET_BITS_CAP : set_bits_ff;
      set_mask     = (9'd1 << set_bits_eff) - 9'd1;
      set_raw      = line[7:0] & set_mask[7:0];
      set_idx      = SET_W'(set_raw);
      tag_cur      = ctc_pkg::TAG_W'(line >> set_bits_eff);
   end

   // Reciprocals for the remainder of the stepped LFSR by the way count.
   for (genvar k = 0; k < MAX_WAYS; k++) begin : g_recip
      localparam logic [ctc_pkg::RECIP_W-1:0] RECIP =
         ctc_pkg::RECIP_W'((64'h1_0000_0000 + 64'(k)) / 64'(k + 1));
      assign recip_tab[k] = RECIP;
   end

   always_comb begin
      lfsr_nxt   = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                    lfsr_ff[ctc_pkg::LFSR_W-1:1]};
      recip_idx  = WAY_W'(ways_eff - WCNT_W'(1));
      recip_prod = PROD_W'(lfsr_nxt) * PROD_W'(recip_tab[recip_idx]);
      rnd_rem    = lfsr_nxt - ctc_pkg::LFSR_W'(quot_ff * ctc_pkg::LFSR_W'(ways_eff));
      rnd_way    = WAY_W'(rnd_rem);
      stamp_new  = counter_ff + 32'd1;
   end

   // State machine: next state.
   always_comb begin
      unique case (state_ff)
         ctc_pkg::ST_IDLE:   state_in = accept ? ctc_pkg::ST_UPDATE : ctc_pkg::ST_IDLE;
         ctc_pkg::ST_UPDATE: state_in = ctc_pkg::ST_IDLE;
         default:            state_in = ctc_pkg::ST_IDLE;
      endcase
   end

   // State machine: outputs.
   always_comb begin
      req_ready = 1'b0;
      update    = 1'b0;
      unique case (state_ff)
         ctc_pkg::ST_IDLE:   req_ready = !rsp_valid_ff || rsp_bus.ready;
         ctc_pkg::ST_UPDATE: update    = 1'b1;
         default: ;
      endcase
   end

   assign accept        = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Access capture on transfer. The quotient fits in the LFSR width.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_bus.operation;
         set_ff  <= set_idx;
         tag_ff  <= tag_cur;
         quot_ff <= recip_prod[PROD_W-2:ctc_pkg::RECIP_W-1];
      end
   end

   // The counter advances in every row update, the LFSR only on a random victim.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         lfsr_ff    <= ctc_pkg::LFSR_SEED;
      end else if (update) begin
         counter_ff <= stamp_new;
         if (ctl.lfsr_step) begin
            lfsr_ff <= lfsr_nxt;
         end
      end
   end

   ctc_row_ram #(
      .SETS  (MAX_SETS),
      .WAYS  (MAX_WAYS),
      .SET_W (SET_W),
      .WAY_W (WAY_W)
   ) u_row_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (set_idx),
      .rd_tags   (rd_tags),
      .rd_stamps (rd_stamps),
      .rd_valid  (rd_valid),
      .rd_dirty  (rd_dirty),
      .rd_ptr    (rd_ptr),
      .wr_en     (update),
      .wr_addr   (set_ff),
      .wr_tags   (new_tags),
      .wr_stamps (new_stamps),
      .wr_valid  (new_valid),
      .wr_dirty  (new_dirty),
      .wr_ptr    (new_ptr)
   );

   ctc_lookup #(
      .WAYS   (MAX_WAYS),
      .WAY_W  (WAY_W),
      .WCNT_W (WCNT_W)
   ) u_lookup (
      .row_tags    (rd_tags),
      .row_stamps  (rd_stamps),
      .row_valid   (rd_valid),
      .row_dirty   (rd_dirty),
      .row_ptr     (rd_ptr),
      .operation   (op_ff),
      .tag         (tag_ff),
      .ways_eff    (ways_eff),
      .replacement (replacement_ff),
      .write_mode  (write_mode_ff),
      .rnd_way     (rnd_way),
      .stamp_new   (stamp_new),
      .ctl         (ctl),
      .new_tags    (new_tags),
      .new_stamps  (new_stamps),
      .new_valid   (new_valid),
      .new_dirty   (new_dirty),
      .new_ptr     (new_ptr)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_hit_ff <= ctl.hit;
         rsp_set_ff <= ctc_pkg::SET_OUT_W'(set_ff);
         rsp_tag_ff <= tag_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.hit       = rsp_hit_ff;
   assign rsp_bus.set_index = rsp_set_ff;
   assign rsp_bus.tag_value = rsp_tag_ff;

   // The result register is free whenever a row update runs.
   a_rsp_free_in_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctc_pkg::ST_UPDATE |-> !rsp_valid_ff)
      else $error("result register busy during row update");

   // A transfer is followed by exactly one row update and one result.
   a_accept_then_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ctc_pkg::ST_UPDATE) ##1 rsp_bus.valid)
      else $error("access transfer not followed by update and result");

   // A hit never allocates a new line.
   a_hit_no_alloc: assert property (@(posedge clock) disable iff (reset)
      update |-> !(ctl.hit && ctl.alloc))
      else $error("hit and allocation in the same update");

endmodule

`default_nettype wire
